// File: rtl/sstt_pkg.sv
`default_nettype none
package sstt_pkg;
  localparam int unsigned SlotsDefault = 16;
  localparam int unsigned SlotW = 4;
  localparam int unsigned TaskW = 5;
  localparam int unsigned CountW = 32;
  localparam int unsigned DataW = 8;
  localparam int unsigned QueueDepth = 2;

  localparam logic [2:0] ReqTick  = 3'd0;
  localparam logic [2:0] ReqAlloc = 3'd1;
  localparam logic [2:0] ReqFree  = 3'd2;
  localparam logic [2:0] ReqInit  = 3'd3;
  localparam logic [2:0] ReqSet   = 3'd4;

  localparam logic [1:0] KindGrant   = 2'd0;
  localparam logic [1:0] KindFail    = 2'd1;
  localparam logic [1:0] KindExpiry  = 2'd2;
  localparam logic [1:0] KindSwitch  = 2'd3;

  typedef struct packed {
    logic [2:0]        req;
    logic [SlotW-1:0]  slot;
    logic [CountW-1:0] timeout;
    logic [DataW-1:0]  payload;
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic [1:0]       kind;
    logic [SlotW-1:0] slot;
    logic [DataW-1:0] data;
    logic             last;
  } resp_t;
endpackage
`default_nettype wire

// File: rtl/sorted_software_timer_table_core.sv
`default_nettype none
// sorted timer table: a two-entry command queue feeds a sequencer that walks
// the armed list one entry a cycle. alloc scans the slots for a free one, set
// runs an unlink walk then an insert walk, tick pops every expired slot;
// results come out as single-cycle strobes and cannot be stalled. busy_o
// is high only while the queue is full.
module sorted_software_timer_table_core #(
  parameter int unsigned Slots = sstt_pkg::SlotsDefault
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start_i,
  output logic                       busy_o,
  input  wire [2:0]                  req_type_i,
  input  wire [3:0]                  slot_i,
  input  wire [31:0]                 timeout_i,
  input  wire [7:0]                  payload_i,
  input  wire                        cfg_we_i,
  input  wire [4:0]                  cfg_wdata_i,
  output logic                       resp_valid_o,
  output logic [1:0]                 resp_kind_o,
  output logic [3:0]                 resp_slot_o,
  output logic [7:0]                 resp_data_o,
  output logic                       last_o
);
  import sstt_pkg::*;
  logic [TaskW-1:0] task_q;
  cmd_t  cmd, head;
  resp_t resp;
  logic  deq, head_valid, ready, idle;

  assign cmd = '{req_type_i, slot_i, timeout_i, payload_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) task_q <= TaskW'(16);
    else if (cfg_we_i) task_q <= cfg_wdata_i;
  end

  sstt_front u_front (
    .clk_i, .rst_ni, .start_i, .cmd_i(cmd), .back_ready_i(ready),
    .busy_o, .deq_o(deq), .head_o(head), .head_valid_o(head_valid)
  );

  sstt_back #(.Slots(Slots)) u_back (
    .clk_i, .rst_ni, .task_slot_i(task_q), .head_valid_i(head_valid && deq),
    .head_i(head), .ready_o(ready), .idle_o(idle), .resp_o(resp)
  );

  assign resp_valid_o = resp.valid && !idle ? resp.valid : resp.valid;
  assign resp_kind_o  = resp.kind;
  assign resp_slot_o  = resp.slot;
  assign resp_data_o  = resp.data;
  assign last_o       = resp.last;
endmodule
`default_nettype wire

// File: rtl/sstt_front.sv
`default_nettype none
module sstt_front (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  input  sstt_pkg::cmd_t    cmd_i,
  input  wire               back_ready_i,
  output logic              busy_o,
  output logic              deq_o,
  output sstt_pkg::cmd_t    head_o,
  output logic              head_valid_o
);
  import sstt_pkg::*;
  // small fifo; unknown request codes are dropped here
  cmd_t      q_q [QueueDepth];
  logic [1:0] cnt_q;
  logic       rd_q, wr_q;
  logic       enq, known;

  assign busy_o = (cnt_q == 2'(QueueDepth));
  assign known = (cmd_i.req == ReqTick) || (cmd_i.req == ReqAlloc) ||
                 (cmd_i.req == ReqFree) || (cmd_i.req == ReqInit) ||
                 (cmd_i.req == ReqSet);
  assign enq = start_i && !busy_o && known;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o = q_q[rd_q];
  assign deq_o = head_valid_o && back_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      if (enq) begin
        q_q[wr_q] <= cmd_i;
        wr_q <= !wr_q;
      end
      if (deq_o) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, enq} - {1'b0, deq_o};
    end
  end
endmodule
`default_nettype wire

// File: rtl/sstt_back.sv
`default_nettype none
module sstt_back #(
  parameter int unsigned Slots = sstt_pkg::SlotsDefault
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire [sstt_pkg::TaskW-1:0]    task_slot_i,
  input  wire                          head_valid_i,
  input  sstt_pkg::cmd_t               head_i,
  output logic                         ready_o,
  output logic                         idle_o,
  output sstt_pkg::resp_t              resp_o
);
  import sstt_pkg::*;
  localparam int unsigned IW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned NW = $clog2(Slots + 1);

  typedef enum logic [2:0] {
    StIdle, StAlloc, StUnlink, StInsert, StExpire, StSwitch
  } state_e;

  state_e            state_q;
  logic [1:0]        status_q [Slots];
  logic [CountW-1:0] deadline_q [Slots];
  logic [DataW-1:0]  payload_q [Slots];
  logic [IW-1:0]     order_q [Slots];
  logic [NW-1:0]     total_q;
  logic [CountW-1:0] count_q;
  logic [NW-1:0]     idx_q;
  logic [IW-1:0]     slot_q;
  logic [CountW-1:0] dl_q;
  logic              set_q, ts_q, found_q;
  resp_t             resp_q;
  logic [IW-1:0]     cur;
  logic              in_rng;

  assign ready_o = (state_q == StIdle);
  assign idle_o  = (state_q == StIdle) && !head_valid_i;
  assign resp_o  = resp_q;
  assign cur = order_q[idx_q[IW-1:0]];
  assign in_rng = ({{(32-SlotW){1'b0}}, head_i.slot} < Slots);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      total_q <= '0;
      count_q <= '0;
      resp_q  <= '0;
      for (int i = 0; i < Slots; i++) status_q[i] <= 2'd0;
    end else begin
      resp_q.valid <= 1'b0;
      case (state_q)
        StIdle: begin
          if (head_valid_i) begin
            slot_q <= IW'(head_i.slot);
            idx_q  <= '0;
            ts_q   <= 1'b0;
            found_q <= 1'b0;
            case (head_i.req)
              ReqTick: begin
                count_q <= count_q + 1'b1;
                dl_q    <= count_q + 1'b1;
                state_q <= StExpire;
              end
              ReqAlloc: state_q <= StAlloc;
              ReqFree: begin
                if (in_rng) begin
                  set_q <= 1'b0;
                  if (status_q[IW'(head_i.slot)] == 2'd2) state_q <= StUnlink;
                  status_q[IW'(head_i.slot)] <= 2'd0;
                end
              end
              ReqInit: if (in_rng) payload_q[IW'(head_i.slot)] <= head_i.payload;
              ReqSet: begin
                if (in_rng) begin
                  set_q <= 1'b1;
                  dl_q <= count_q + head_i.timeout;
                  deadline_q[IW'(head_i.slot)] <= count_q + head_i.timeout;
                  state_q <= (status_q[IW'(head_i.slot)] == 2'd2) ? StUnlink : StInsert;
                  status_q[IW'(head_i.slot)] <= 2'd2;
                end
              end
              default: ;
            endcase
          end
        end
        // one slot checked per cycle
        StAlloc: begin
          if (status_q[idx_q[IW-1:0]] == 2'd0) begin
            status_q[idx_q[IW-1:0]] <= 2'd1;
            resp_q <= '{1'b1, KindGrant, SlotW'(idx_q), '0, 1'b1};
            state_q <= StIdle;
          end else if (idx_q == NW'(Slots - 1)) begin
            resp_q <= '{1'b1, KindFail, '0, '0, 1'b1};
            state_q <= StIdle;
          end else idx_q <= idx_q + 1'b1;
        end
        // walk the list, shift entries down past the removed one
        StUnlink: begin
          if (idx_q >= total_q) begin
            if (found_q) total_q <= total_q - 1'b1;
            idx_q <= '0;
            found_q <= 1'b0;
            state_q <= set_q ? StInsert : StIdle;
          end else begin
            if (found_q || cur == slot_q) begin
              if (idx_q + 1'b1 < total_q) order_q[idx_q[IW-1:0]] <= order_q[IW'(idx_q + 1'b1)];
              found_q <= 1'b1;
            end
            idx_q <= idx_q + 1'b1;
          end
        end
        // walk from the tail, shift deadlines not smaller than the new one up one place
        StInsert: begin
          if (!found_q) begin
            if (total_q >= NW'(Slots)) state_q <= StIdle;
            else begin
              idx_q <= total_q;
              found_q <= 1'b1;
            end
          end else if (idx_q != '0 &&
                       !(deadline_q[order_q[IW'(idx_q - 1'b1)]] < dl_q)) begin
            order_q[idx_q[IW-1:0]] <= order_q[IW'(idx_q - 1'b1)];
            idx_q <= idx_q - 1'b1;
          end else begin
            order_q[idx_q[IW-1:0]] <= slot_q;
            total_q <= total_q + 1'b1;
            state_q <= StIdle;
          end
        end
        // pop due entries from the head, one a cycle
        StExpire: begin
          if (total_q != '0 && deadline_q[order_q[0]] <= dl_q) begin
            status_q[order_q[0]] <= 2'd1;
            for (int i = 0; i + 1 < Slots; i++) order_q[i] <= order_q[i+1];
            total_q <= total_q - 1'b1;
            if ({{(TaskW-IW){1'b0}}, order_q[0]} == task_slot_i &&
                {{(32-TaskW){1'b0}}, task_slot_i} < Slots) ts_q <= 1'b1;
            else begin
              resp_q <= '{1'b1, KindExpiry, SlotW'(order_q[0]), payload_q[order_q[0]],
                          !(total_q > NW'(1) && deadline_q[order_q[1 % Slots]] <= dl_q) && !ts_q};
            end
          end else state_q <= StSwitch;
        end
        StSwitch: begin
          if (ts_q) resp_q <= '{1'b1, KindSwitch, task_slot_i[SlotW-1:0], '0, 1'b1};
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/sstt_checker.sv
`default_nettype none
module sstt_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       resp_valid_o,
  input wire [1:0] resp_kind_o,
  input wire [7:0] resp_data_o,
  input wire       last_o
);
  import sstt_pkg::*;
  a_alloc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_valid_o && (resp_kind_o == KindGrant || resp_kind_o == KindFail) |-> last_o)
    else $error("alloc result without last");
  a_switch_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_valid_o && resp_kind_o == KindSwitch |-> last_o && resp_data_o == '0)
    else $error("bad task switch result");
  a_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_valid_o && last_o |=> !resp_valid_o)
    else $error("result right after last");
endmodule
bind sorted_software_timer_table_core sstt_checker u_chk (
  .clk_i, .rst_ni, .resp_valid_o, .resp_kind_o, .resp_data_o, .last_o
);
`default_nettype wire
